// ===== src/assert_macros.svh =====
// Assertion macros used by the checker module of the voice allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define SVA_CHECK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SVA_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/svalloc_pkg.sv =====
// Package with the constants, codes and types of the voice allocator.
`default_nettype none
package svalloc_pkg;

  localparam int VOICES     = 32;
  localparam int KEYS       = 88;
  localparam int VIDX_W     = $clog2(VOICES);
  localparam int CNT_W      = $clog2(VOICES + 1);
  localparam int KEY_W      = 7;
  localparam int TICK_W     = 32;
  localparam int DUR_W      = 16;
  localparam int MARGIN_W   = 10;
  localparam int FADE_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [DUR_W-1:0]    BUFFER_LIMIT_RST = DUR_W'(4000);
  localparam logic [MARGIN_W-1:0] STOP_MARGIN_RST  = MARGIN_W'(50);
  localparam logic [MARGIN_W-1:0] FADE_LEAD_RST    = MARGIN_W'(30);

  typedef enum logic [1:0] {
    ACT_NOTE_ON  = 2'd0,
    ACT_NOTE_OFF = 2'd1,
    ACT_PLAY     = 2'd2,
    ACT_TICK     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    EV_START   = 2'd0,
    EV_STOP    = 2'd1,
    EV_RELEASE = 2'd2
  } event_t;

  typedef enum logic [1:0] {
    CFG_BUFFER_LIMIT = 2'd0,
    CFG_STOP_MARGIN  = 2'd1,
    CFG_FADE_LEAD    = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPIRE,
    ST_PICK,
    ST_EVICT,
    ST_START,
    ST_OFF_COUNT,
    ST_OFF_EMIT
  } state_t;

  // Results of the shared age unit for the voice under the scan pointer.
  typedef struct packed {
    logic [TICK_W-1:0] age;
    logic              expired;
    logic              past_sus;
    logic              older;
    logic [DUR_W-1:0]  rel_end;
    logic [FADE_W-1:0] fade;
  } age_res_t;

endpackage
`default_nettype wire

// ===== src/svalloc_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none
interface svalloc_in_if;
  import svalloc_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [KEY_W-1:0]    key;
  logic [DUR_W-1:0]    sustain_limit;
  logic [DUR_W-1:0]    release_time;
  logic                skip_note_off;
  logic [DUR_W-1:0]    hold_time;

  modport source (output valid, action, key, sustain_limit, release_time, skip_note_off,
                  hold_time, input ready);
  modport sink (input valid, action, key, sustain_limit, release_time, skip_note_off,
                hold_time, output ready);
endinterface

interface svalloc_out_if;
  import svalloc_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          event_res;
  logic [VIDX_W-1:0]   voice;
  logic [KEY_W-1:0]    note_key;
  logic [DUR_W-1:0]    length;
  logic [FADE_W-1:0]   fade_start;
  logic                last;

  modport source (output valid, event_res, voice, note_key, length, fade_start, last,
                  input ready);
  modport sink (input valid, event_res, voice, note_key, length, fade_start, last,
                output ready);
endinterface
`default_nettype wire

// ===== src/synth_voice_allocator.sv =====
// Polyphonic voice allocator over 32 voices with oldest-voice stealing.
//
// Input channel in_ch carries note-on, note-off, timed play-note and tick
// items; output channel out_ch carries started, stopped and released events,
// with last set on the final result of an item. A transfer happens when valid
// and ready are both high. Registers are written through cfg_write,
// cfg_index and cfg_data; the user must write them only while the block
// is idle, as the block itself does not enforce this. A tick, or a note for
// a key of 88 or above, gives no result and leaves the block ready.
// Note-on and play-note run an expiry pass and a pick pass over all
// voices, then evict and start. Note-off runs a count pass, plus an emit
// pass when some voice matches. All passes share one age unit that looks
// at one voice per cycle while no stalled result holds the scan.
// Results leave through one output register; while the receiver stalls it,
// the scan holds on the voice that has a result to give.
// Reset clears all voices, the tick counter and the output valid flag and
// loads the register defaults; the block is ready right after reset.
`default_nettype none
module synth_voice_allocator (
  input  logic                                clk,
  input  logic                                rst,
  svalloc_in_if.sink                          in_ch,
  svalloc_out_if.source                       out_ch,
  input  logic                                cfg_write,
  input  logic [svalloc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [svalloc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import svalloc_pkg::*;

  logic [DUR_W-1:0]    buffer_limit;
  logic [MARGIN_W-1:0] stop_margin;
  logic [MARGIN_W-1:0] fade_lead;

  logic [TICK_W-1:0]   now_ticks, now_ticks_next;
  logic [VOICES-1:0]   voice_active;
  logic [KEY_W-1:0]    voice_note    [VOICES];
  logic [TICK_W-1:0]   voice_start   [VOICES];
  logic [DUR_W-1:0]    voice_sustain [VOICES];
  logic [DUR_W-1:0]    voice_release [VOICES];
  logic [DUR_W-1:0]    voice_end     [VOICES];
  logic                voice_ign     [VOICES];

  state_t              state, state_next;
  logic [VIDX_W-1:0]   idx, idx_next;
  logic [CNT_W-1:0]    cnt, cnt_next;

  logic [1:0]          action_q;
  logic [KEY_W-1:0]    key_q;
  logic [DUR_W-1:0]    sus_q, rel_q, hold_q;
  logic                ign_q;

  logic                found_match, found_match_next;
  logic [VIDX_W-1:0]   match_idx, match_idx_next;
  logic                found_free, found_free_next;
  logic [VIDX_W-1:0]   free_idx, free_idx_next;
  logic [VIDX_W-1:0]   best_idx, best_idx_next;
  logic [TICK_W-1:0]   best_age, best_age_next;
  logic [KEY_W-1:0]    best_note, best_note_next;

  logic                in_fire, last_idx, key_same, key_hit, match_key, can_emit;
  logic                chosen_active;
  logic [VIDX_W-1:0]   chosen_v;
  logic [KEY_W-1:0]    chosen_note;
  logic                clr_idx, upd_end, do_start;
  logic [DUR_W-1:0]    start_len;
  logic [FADE_W-1:0]   start_fade;
  logic [DUR_W:0]      want;

  logic                emit;
  event_t              e_res;
  logic [VIDX_W-1:0]   e_voice;
  logic [KEY_W-1:0]    e_key;
  logic [DUR_W-1:0]    e_len;
  logic [FADE_W-1:0]   e_fade;
  logic                e_last;

  age_res_t            au;

  svalloc_age_unit u_age (
    .now_ticks    (now_ticks),
    .start_ticks  (voice_start[idx]),
    .end_ticks    (voice_end[idx]),
    .sustain      (voice_sustain[idx]),
    .release_len  (voice_release[idx]),
    .stop_margin  (stop_margin),
    .fade_lead    (fade_lead),
    .buffer_limit (buffer_limit),
    .best_age     (best_age),
    .res          (au)
  );

  assign in_ch.ready = (state == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign last_idx    = (idx == VIDX_W'(VOICES - 1));
  // Note-on reuses a voice on the same key even when that voice ignores
  // note-off; note-off itself skips such voices.
  assign key_same    = voice_active[idx] && (voice_note[idx] == key_q);
  assign key_hit     = key_same && !voice_ign[idx];
  assign match_key   = (action_q == ACT_NOTE_ON) && !ign_q;
  assign can_emit    = !out_ch.valid || out_ch.ready;

  // A same-key match wins, then the first free voice, then the oldest.
  assign chosen_active = found_match || !found_free;
  assign chosen_v      = found_match ? match_idx : (found_free ? free_idx : best_idx);
  assign chosen_note   = found_match ? key_q : best_note;

  always_comb begin
    want = {1'b0, hold_q} + {1'b0, rel_q};
    if (action_q == ACT_NOTE_ON || ign_q) begin
      start_len  = (sus_q < buffer_limit) ? sus_q : buffer_limit;
      start_fade = '0;
    end else begin
      start_len  = (want < {1'b0, buffer_limit}) ? want[DUR_W-1:0] : buffer_limit;
      start_fade = (hold_q < buffer_limit) ? {1'b0, hold_q} : '0;
    end
  end

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    cnt_next         = cnt;
    now_ticks_next   = now_ticks;
    found_match_next = found_match;
    match_idx_next   = match_idx;
    found_free_next  = found_free;
    free_idx_next    = free_idx;
    best_idx_next    = best_idx;
    best_age_next    = best_age;
    best_note_next   = best_note;
    emit             = 1'b0;
    e_res            = EV_STOP;
    e_voice          = idx;
    e_key            = voice_note[idx];
    e_len            = '0;
    e_fade           = '0;
    e_last           = 1'b0;
    clr_idx          = 1'b0;
    upd_end          = 1'b0;
    do_start         = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          idx_next         = '0;
          cnt_next         = '0;
          found_match_next = 1'b0;
          found_free_next  = 1'b0;
          if (in_ch.action == ACT_TICK) begin
            now_ticks_next = now_ticks + TICK_W'(1);
          end else if ({1'b0, in_ch.key} < (KEY_W+1)'(KEYS)) begin
            state_next = (in_ch.action == ACT_NOTE_OFF) ? ST_OFF_COUNT : ST_EXPIRE;
          end
        end
      end
      ST_EXPIRE: begin
        if (!(voice_active[idx] && au.expired) || can_emit) begin
          if (voice_active[idx] && au.expired) begin
            emit    = 1'b1;
            clr_idx = 1'b1;
          end
          idx_next = idx + VIDX_W'(1);
          if (last_idx) state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        if (match_key && key_same && !found_match) begin
          found_match_next = 1'b1;
          match_idx_next   = idx;
        end
        if (!voice_active[idx] && !found_free) begin
          found_free_next = 1'b1;
          free_idx_next   = idx;
        end
        if (idx == '0 || au.older) begin
          best_idx_next  = idx;
          best_age_next  = au.age;
          best_note_next = voice_note[idx];
        end
        idx_next = idx + VIDX_W'(1);
        if (last_idx) state_next = ST_EVICT;
      end
      ST_EVICT: begin
        if (!chosen_active) begin
          state_next = ST_START;
        end else if (can_emit) begin
          emit       = 1'b1;
          e_voice    = chosen_v;
          e_key      = chosen_note;
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (can_emit) begin
          emit       = 1'b1;
          e_res      = EV_START;
          e_voice    = chosen_v;
          e_key      = key_q;
          e_len      = start_len;
          e_fade     = start_fade;
          e_last     = 1'b1;
          do_start   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_OFF_COUNT: begin
        if (key_hit) cnt_next = cnt + CNT_W'(1);
        idx_next = idx + VIDX_W'(1);
        if (last_idx) state_next = (cnt_next == '0) ? ST_IDLE : ST_OFF_EMIT;
      end
      ST_OFF_EMIT: begin
        if (!key_hit || can_emit) begin
          if (key_hit) begin
            emit     = 1'b1;
            e_key    = key_q;
            e_last   = (cnt == CNT_W'(1));
            cnt_next = cnt - CNT_W'(1);
            if (au.past_sus) begin
              clr_idx = 1'b1;
            end else begin
              e_res   = EV_RELEASE;
              e_len   = au.rel_end;
              e_fade  = au.fade;
              upd_end = 1'b1;
            end
          end
          idx_next = idx + VIDX_W'(1);
          if (last_idx) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      idx          <= '0;
      cnt          <= '0;
      now_ticks    <= '0;
      voice_active <= '0;
      found_match  <= 1'b0;
      found_free   <= 1'b0;
      buffer_limit <= BUFFER_LIMIT_RST;
      stop_margin  <= STOP_MARGIN_RST;
      fade_lead    <= FADE_LEAD_RST;
      out_ch.valid <= 1'b0;
    end else begin
      state       <= state_next;
      idx         <= idx_next;
      cnt         <= cnt_next;
      now_ticks   <= now_ticks_next;
      found_match <= found_match_next;
      found_free  <= found_free_next;
      if (clr_idx) voice_active[idx] <= 1'b0;
      if (do_start) voice_active[chosen_v] <= 1'b1;
      if (cfg_write) begin
        case (cfg_index)
          CFG_BUFFER_LIMIT: buffer_limit <= cfg_data[DUR_W-1:0];
          CFG_STOP_MARGIN:  stop_margin  <= cfg_data[MARGIN_W-1:0];
          CFG_FADE_LEAD:    fade_lead    <= cfg_data[MARGIN_W-1:0];
          default: ;
        endcase
      end
      if (emit) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    match_idx <= match_idx_next;
    free_idx  <= free_idx_next;
    best_idx  <= best_idx_next;
    best_age  <= best_age_next;
    best_note <= best_note_next;
    if (in_fire) begin
      action_q <= in_ch.action;
      key_q    <= in_ch.key;
      sus_q    <= in_ch.sustain_limit;
      rel_q    <= in_ch.release_time;
      ign_q    <= in_ch.skip_note_off;
      hold_q   <= in_ch.hold_time;
    end
    if (upd_end) voice_end[idx] <= au.rel_end;
    if (do_start) begin
      voice_note[chosen_v]    <= key_q;
      voice_start[chosen_v]   <= now_ticks;
      voice_sustain[chosen_v] <= sus_q;
      voice_release[chosen_v] <= rel_q;
      voice_end[chosen_v]     <= start_len;
      voice_ign[chosen_v]     <= ign_q;
    end
    if (emit) begin
      out_ch.event_res  <= e_res;
      out_ch.voice      <= e_voice;
      out_ch.note_key   <= e_key;
      out_ch.length     <= e_len;
      out_ch.fade_start <= e_fade;
      out_ch.last       <= e_last;
    end
  end

endmodule
`default_nettype wire

// ===== src/svalloc_age_unit.sv =====
// Shared age unit: age, expiry, release end and fade for one voice per cycle.
`default_nettype none
module svalloc_age_unit (
  input  logic [svalloc_pkg::TICK_W-1:0]   now_ticks,
  input  logic [svalloc_pkg::TICK_W-1:0]   start_ticks,
  input  logic [svalloc_pkg::DUR_W-1:0]    end_ticks,
  input  logic [svalloc_pkg::DUR_W-1:0]    sustain,
  input  logic [svalloc_pkg::DUR_W-1:0]    release_len,
  input  logic [svalloc_pkg::MARGIN_W-1:0] stop_margin,
  input  logic [svalloc_pkg::MARGIN_W-1:0] fade_lead,
  input  logic [svalloc_pkg::DUR_W-1:0]    buffer_limit,
  input  logic [svalloc_pkg::TICK_W-1:0]   best_age,
  output svalloc_pkg::age_res_t            res
);
  import svalloc_pkg::*;

  logic [TICK_W-1:0]  age;
  logic [DUR_W+1:0]   rel_sum;
  logic [FADE_W-1:0]  fade_sum;

  // Release arithmetic only matters when age is below the sustain, so the
  // low half of the age is all it needs.
  always_comb begin
    age      = now_ticks - start_ticks;
    rel_sum  = {2'b00, age[DUR_W-1:0]} + {2'b00, release_len} + (DUR_W+2)'(stop_margin);
    fade_sum = {1'b0, age[DUR_W-1:0]} + FADE_W'(fade_lead);
    res.age      = age;
    res.expired  = age >= TICK_W'(end_ticks);
    res.past_sus = age >= TICK_W'(sustain);
    res.older    = age > best_age;
    res.rel_end  = (rel_sum < (DUR_W+2)'(end_ticks)) ? rel_sum[DUR_W-1:0] : end_ticks;
    res.fade     = (fade_sum >= FADE_W'(buffer_limit)) ? '0 : fade_sum;
  end

endmodule
`default_nettype wire

// ===== src/svalloc_checker.sv =====
// Port-level checker for the voice allocator and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module svalloc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [1:0]                      in_action,
  input logic [svalloc_pkg::KEY_W-1:0]   in_key,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [1:0]                      out_event_res,
  input logic [svalloc_pkg::DUR_W-1:0]   out_length,
  input logic [svalloc_pkg::FADE_W-1:0]  out_fade_start
);
  import svalloc_pkg::*;

  `SVA_CHECK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `SVA_CHECK(a_note_busy, clk, rst, in_valid && in_ready && in_action != ACT_TICK && {1'b0, in_key} < (KEY_W+1)'(KEYS) |=> !in_ready, "note transfer did not start a scan")
  `SVA_CHECK(a_tick_free, clk, rst, in_valid && in_ready && in_action == ACT_TICK |=> in_ready, "tick made the block busy")
  `SVA_CHECK(a_stop_zero, clk, rst, out_valid && out_event_res == EV_STOP |-> out_length == '0 && out_fade_start == '0, "stopped result carries length or fade")
  `SVA_ALWAYS(a_reset_empty, clk, $past(rst) |-> !out_valid, "result present right after reset")

endmodule

bind synth_voice_allocator svalloc_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_action      (in_ch.action),
  .in_key         (in_ch.key),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_event_res  (out_ch.event_res),
  .out_length     (out_ch.length),
  .out_fade_start (out_ch.fade_start)
);
`default_nettype wire

// ===== verif/synth_voice_allocator_tb.sv =====
// Self-checking testbench for the voice allocator: directed and random items against a predictor.
`default_nettype none
module synth_voice_allocator_tb;
  import svalloc_pkg::*;

  typedef struct packed {
    action_t          action;
    logic [KEY_W-1:0] key;
    logic [DUR_W-1:0] sus;
    logic [DUR_W-1:0] rel;
    logic             ign;
    logic [DUR_W-1:0] hold;
  } note_item_t;

  typedef struct packed {
    event_t            ev;
    logic [VIDX_W-1:0] voice;
    logic [KEY_W-1:0]  key;
    logic [DUR_W-1:0]  len;
    logic [FADE_W-1:0] fade;
    logic              last;
  } voice_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  svalloc_in_if  in_ch();
  svalloc_out_if out_ch();

  synth_voice_allocator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Predictor state.
  logic [DUR_W-1:0]    buf_limit;
  logic [MARGIN_W-1:0] margin;
  logic [MARGIN_W-1:0] lead;
  logic [TICK_W-1:0]   now;
  logic                v_active [VOICES];
  logic [KEY_W-1:0]    v_note   [VOICES];
  logic [TICK_W-1:0]   v_start  [VOICES];
  logic [DUR_W-1:0]    v_sus    [VOICES];
  logic [DUR_W-1:0]    v_rel    [VOICES];
  logic [DUR_W-1:0]    v_end    [VOICES];
  logic                v_ign    [VOICES];

  voice_event_t pending_events[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int starts_seen = 0;
  int stops_seen = 0;
  int releases_seen = 0;
  int hold_req = 0;
  int hold_left = 0;
  bit rx_always_ready = 1'b0;
  bit tx_no_gaps = 1'b0;

  task automatic allocate_voices(input note_item_t it);
    voice_event_t evs[$];
    voice_event_t e;
    logic [TICK_W-1:0] age, fade, fin, len, want;
    logic [TICK_W-1:0] best_age;
    int v;
    bit found;
    if (it.action == ACT_TICK) begin
      now = now + 1;
      return;
    end
    if (it.key >= KEYS) return;
    if (it.action == ACT_NOTE_OFF) begin
      for (int i = 0; i < VOICES; i++) begin
        if (!v_active[i] || v_note[i] != it.key || v_ign[i]) continue;
        age = now - v_start[i];
        if (age >= v_sus[i]) begin
          v_active[i] = 1'b0;
          e = '{EV_STOP, VIDX_W'(i), it.key, '0, '0, 1'b0};
          evs.push_back(e);
          continue;
        end
        fade = age + lead;
        if (fade >= buf_limit) fade = 0;
        fin = age + v_rel[i] + margin;
        if (fin < v_end[i]) v_end[i] = fin[DUR_W-1:0];
        e = '{EV_RELEASE, VIDX_W'(i), it.key, v_end[i], fade[FADE_W-1:0], 1'b0};
        evs.push_back(e);
      end
    end else begin
      // Expiry pass comes first on every note-on and play-note.
      for (int i = 0; i < VOICES; i++) begin
        if (v_active[i] && (now - v_start[i]) >= v_end[i]) begin
          v_active[i] = 1'b0;
          e = '{EV_STOP, VIDX_W'(i), v_note[i], '0, '0, 1'b0};
          evs.push_back(e);
        end
      end
      found = 1'b0;
      v = 0;
      if (it.action == ACT_NOTE_ON && !it.ign) begin
        for (int i = 0; i < VOICES && !found; i++) begin
          if (v_active[i] && v_note[i] == it.key) begin
            v = i;
            found = 1'b1;
          end
        end
      end
      for (int i = 0; i < VOICES && !found; i++) begin
        if (!v_active[i]) begin
          v = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        best_age = now - v_start[0];
        for (int i = 1; i < VOICES; i++) begin
          age = now - v_start[i];
          if (age > best_age) begin
            best_age = age;
            v = i;
          end
        end
      end
      if (v_active[v]) begin
        e = '{EV_STOP, VIDX_W'(v), v_note[v], '0, '0, 1'b0};
        evs.push_back(e);
      end
      fade = 0;
      if (it.action == ACT_NOTE_ON || it.ign) begin
        len = (it.sus < buf_limit) ? it.sus : buf_limit;
      end else begin
        want = it.hold + it.rel;
        len = (want < buf_limit) ? want : buf_limit;
        if (it.hold < buf_limit) fade = it.hold;
      end
      v_active[v] = 1'b1;
      v_note[v]   = it.key;
      v_start[v]  = now;
      v_sus[v]    = it.sus;
      v_rel[v]    = it.rel;
      v_end[v]    = len[DUR_W-1:0];
      v_ign[v]    = it.ign;
      e = '{EV_START, VIDX_W'(v), it.key, len[DUR_W-1:0], fade[FADE_W-1:0], 1'b0};
      evs.push_back(e);
    end
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    foreach (evs[k]) pending_events.push_back(evs[k]);
  endtask

  function automatic int pick_gap();
    int r;
    if (tx_no_gaps) return 0;
    r = $urandom_range(0, 15);
    if (r < 9) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at a falling edge; returns at a falling edge after the transfer.
  task automatic send_note(input note_item_t it);
    int gap;
    in_ch.valid = 1'b1;
    in_ch.action = it.action;
    in_ch.key = it.key;
    in_ch.sustain_limit = it.sus;
    in_ch.release_time = it.rel;
    in_ch.skip_note_off = it.ign;
    in_ch.hold_time = it.hold;
    do @(posedge clk); while (!in_ch.ready);
    allocate_voices(it);
    items_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_fields(input action_t a, input int key, input int sus, input int rel,
                             input bit ign, input int hold);
    note_item_t it;
    it = '{a, KEY_W'(key), DUR_W'(sus), DUR_W'(rel), ign, DUR_W'(hold)};
    send_note(it);
  endtask

  // Waits until every expected result is in, then lets a scan that gives no result finish.
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_DATA_W'(value);
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      CFG_BUFFER_LIMIT: buf_limit = DUR_W'(value);
      CFG_STOP_MARGIN:  margin = MARGIN_W'(value);
      CFG_FADE_LEAD:    lead = MARGIN_W'(value);
      default: ;
    endcase
  endtask

  task automatic set_regs(input int bl, input int sm, input int fl);
    wait_idle();
    write_reg(CFG_BUFFER_LIMIT, bl);
    write_reg(CFG_STOP_MARGIN, sm);
    write_reg(CFG_FADE_LEAD, fl);
  endtask

  function automatic note_item_t random_note();
    note_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) it.action = ACT_NOTE_ON;
    else if (r < 55) it.action = ACT_NOTE_OFF;
    else if (r < 75) it.action = ACT_PLAY;
    else it.action = ACT_TICK;
    r = $urandom_range(0, 9);
    if (r < 8) it.key = KEY_W'($urandom_range(0, 11));
    else if (r < 9) it.key = KEY_W'($urandom_range(0, KEYS - 1));
    else it.key = KEY_W'($urandom_range(0, 127));
    it.sus  = ($urandom_range(0, 9) < 7) ? DUR_W'($urandom_range(0, 40)) : DUR_W'($urandom);
    it.rel  = ($urandom_range(0, 9) < 7) ? DUR_W'($urandom_range(0, 40)) : DUR_W'($urandom);
    it.hold = ($urandom_range(0, 9) < 7) ? DUR_W'($urandom_range(0, 40)) : DUR_W'($urandom);
    it.ign  = ($urandom_range(0, 4) == 0);
    return it;
  endfunction

  // Receiver: random ready with short and occasional long stalls.
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready = 1'b0;
    end else if (rx_always_ready) begin
      out_ch.ready = 1'b1;
    end else if ($urandom_range(0, 99) == 0) begin
      hold_left = $urandom_range(15, 50);
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    voice_event_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_events.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: event %0d voice %0d key %0d",
                                   out_ch.event_res, out_ch.voice, out_ch.note_key);
      end else begin
        want = pending_events.pop_front();
        case (want.ev)
          EV_START:   starts_seen++;
          EV_STOP:    stops_seen++;
          EV_RELEASE: releases_seen++;
          default: ;
        endcase
        if (out_ch.event_res !== want.ev || out_ch.voice !== want.voice ||
            out_ch.note_key !== want.key || out_ch.length !== want.len ||
            out_ch.fade_start !== want.fade || out_ch.last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp ev %0d v %0d key %0d len %0d fade %0d last %0d, got ev %0d v %0d key %0d len %0d fade %0d last %0d",
                     want.ev, want.voice, want.key, want.len, want.fade, want.last,
                     out_ch.event_res, out_ch.voice, out_ch.note_key, out_ch.length,
                     out_ch.fade_start, out_ch.last);
        end
      end
    end
  end

  task automatic test_single_notes();
    send_fields(ACT_NOTE_ON, 0, 65535, 150, 0, 0);      // clipped to the buffer limit
    send_fields(ACT_NOTE_ON, KEYS - 1, 10, 150, 0, 0);
    send_fields(ACT_NOTE_ON, KEYS, 10, 150, 0, 0);      // rejected key
    send_fields(ACT_NOTE_OFF, 127, 0, 0, 0, 0);         // rejected key
    send_fields(ACT_PLAY, 5, 4000, 200, 0, 100);
    send_fields(ACT_PLAY, 6, 300, 200, 1, 100);
    send_fields(ACT_PLAY, 7, 4000, 65535, 0, 65535);    // hold past the limit, no fade
    send_fields(ACT_TICK, 0, 0, 0, 0, 0);
  endtask

  task automatic test_same_key();
    send_fields(ACT_NOTE_ON, 0, 500, 20, 0, 0);         // reuses the voice on key 0
    send_fields(ACT_NOTE_ON, 0, 500, 20, 1, 0);         // ignores note-off, takes a new voice
    send_fields(ACT_NOTE_OFF, 0, 0, 0, 0, 0);
    send_fields(ACT_NOTE_ON, 9, 0, 20, 0, 0);
    send_fields(ACT_NOTE_OFF, 9, 0, 0, 0, 0);           // past sustain, stops
    send_fields(ACT_NOTE_OFF, 50, 0, 0, 0, 0);          // nothing held on that key
    send_fields(ACT_NOTE_OFF, 6, 0, 0, 0, 0);           // play-note that ignores note-off
  endtask

  task automatic test_expiry();
    set_regs(3, 0, 1023);
    send_fields(ACT_NOTE_ON, 20, 2, 5, 0, 0);
    send_fields(ACT_PLAY, 21, 9, 1, 0, 1);
    repeat (4) send_fields(ACT_TICK, 0, 0, 0, 0, 0);
    send_fields(ACT_NOTE_ON, 22, 1, 1, 0, 0);           // expires everything that has ended
  endtask

  task automatic test_steal();
    set_regs(65535, 1023, 0);
    for (int i = 0; i < VOICES + 2; i++) begin
      send_fields(ACT_NOTE_ON, i, 65535, 65535, 0, 0);
      if (i % 3 == 0) send_fields(ACT_TICK, 0, 0, 0, 0, 0);
    end
    send_fields(ACT_PLAY, 60, 65535, 10, 0, 10);
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_req = 300;
    tx_no_gaps = 1'b1;
    for (int i = 0; i < 30; i++) send_note(random_note());
    tx_no_gaps = 1'b0;
    wait_idle();
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_note(random_note());
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = '0;
    in_ch.key = '0;
    in_ch.sustain_limit = '0;
    in_ch.release_time = '0;
    in_ch.skip_note_off = 1'b0;
    in_ch.hold_time = '0;
    out_ch.ready = 1'b0;
    buf_limit = BUFFER_LIMIT_RST;
    margin = STOP_MARGIN_RST;
    lead = FADE_LEAD_RST;
    now = '0;
    for (int i = 0; i < VOICES; i++) begin
      v_active[i] = 1'b0;
      v_note[i] = '0;
      v_start[i] = '0;
      v_sus[i] = '0;
      v_rel[i] = '0;
      v_end[i] = '0;
      v_ign[i] = 1'b0;
    end
    repeat (2) @(negedge clk);
    rst = 1'b0;
    test_single_notes();
    test_same_key();
    test_expiry();
    test_steal();
    test_backpressure();
    set_regs(4000, 50, 30);
    test_random(80);
    set_regs(0, 0, 0);
    test_random(50);
    set_regs(65535, 1023, 1023);
    test_random(80);
    set_regs(20, 5, 3);
    rx_always_ready = 1'b1;
    tx_no_gaps = 1'b1;
    test_random(60);
    rx_always_ready = 1'b0;
    tx_no_gaps = 1'b0;
    set_regs($urandom_range(0, 60), $urandom_range(0, 1023), $urandom_range(0, 1023));
    test_random(80);
    set_regs($urandom, $urandom_range(0, 1023), $urandom_range(0, 1023));
    test_random(50);
    wait_idle();
    if (pending_events.size() != 0) errors++;
    $display("Sent %0d items over several register settings; checked %0d results.",
             items_sent, results_seen);
    $display("Started %0d, stopped %0d, released %0d voices; %0d errors.",
             starts_seen, stops_seen, releases_seen, errors);
    if (errors == 0) begin
      $display("** synth_voice_allocator: PASSED **");
    end else begin
      $display("** synth_voice_allocator: FAILED **");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Timeout with %0d results still expected.", pending_events.size());
    $display("** synth_voice_allocator: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
